// ===== hw/rtl/segment_blocked_by_cells_unit_macros.svh =====
// assertion macros shared by the rtl files
`ifndef SEGMENT_BLOCKED_BY_CELLS_UNIT_MACROS_SVH
`define SEGMENT_BLOCKED_BY_CELLS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, off while reset is low
`define SBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property, also sampled during reset
`define SBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SBC_ASSERT(lbl, prop, msg)
`define SBC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/sbc_pkg.sv =====
package sbc_pkg;

  // fixed width of the cell extent fields
  localparam int SIZE_W = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z   = 2'd3;

  // axis under test
  localparam logic AX_X = 1'b0;
  localparam logic AX_Z = 1'b1;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/segment_blocked_by_cells_unit.sv =====
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    cell_x, cell_z, cell_width, cell_depth, flags
// out      output     out_valid/out_ready  cell_blocks, path_blocked, list_done
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// an endpoint cell goes straight to the result; any other cell makes up to
// four passes through the one radix-2 divider, fewer when an axis fails or
// does not move.
// in_ready is high only while the sequencer is idle; one result register
// lets the next item enter while a result waits on out_ready.
// reset (synchronous, rst_n low) clears the segment, state and out_valid registers and the sticky flag.
`include "segment_blocked_by_cells_unit_macros.svh"

module segment_blocked_by_cells_unit #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_cell_x,
  input  logic signed [COORD_BITS-1:0]  in_cell_z,
  input  logic [sbc_pkg::SIZE_W-1:0]    in_cell_width,
  input  logic [sbc_pkg::SIZE_W-1:0]    in_cell_depth,
  input  logic                          in_is_endpoint,
  input  logic                          in_last_cell,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_cell_blocks,
  output logic                          out_path_blocked,
  output logic                          out_list_done
);

  localparam int C   = COORD_BITS;
  localparam int SW  = sbc_pkg::SIZE_W;
  localparam int MX  = (C > SW) ? C : SW;
  localparam int BW  = MX + 2;
  localparam int NW  = MX + 3;
  localparam int DW  = C + 2;
  localparam int TW  = FRAC_BITS + 2;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_AXIS   = 3'd1;
  localparam logic [2:0] ST_DIV_LO = 3'd2;
  localparam logic [2:0] ST_DIV_HI = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // segment registers
  logic signed [C-1:0] sx_r, sz_r, ex_r, ez_r;

  // sequencer state
  logic [2:0]           state_r, state_nxt;
  logic                 axis_r, axis_nxt;
  logic signed [C-1:0]  cx_r, cx_nxt, cz_r, cz_nxt;
  logic [SW-1:0]        cw_r, cw_nxt, cd_r, cd_nxt;
  logic                 last_r, last_nxt;
  logic                 hit_r, hit_nxt;
  logic signed [TW-1:0] entry_r, entry_nxt, exit_r, exit_nxt, t1_r, t1_nxt;
  logic                 seen_r, seen_nxt;
  logic                 ov_r, ov_nxt, ob_r, ob_nxt, op_r, op_nxt, ol_r, ol_nxt;

  // per axis operands
  logic signed [C-1:0]  p1, p2, cc;
  logic [SW-1:0]        size;
  logic signed [BW-1:0] c2, sz_e, lo, hi, s;
  logic signed [C:0]    diff;
  logic signed [DW-1:0] d;
  logic                 dzero, start_in_slab;
  logic signed [NW-1:0] num_lo, num_hi, div_num;

  // interval update
  logic signed [TW-1:0] t_div, tmin, tmax, ne, nx;
  logic                 ok;

  logic                 div_start;
  sbc_pkg::div_stat_t   div_stat;

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sz_r <= '0;
      ex_r <= '0;
      ez_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbc_pkg::REG_START_X: sx_r <= cfg_data;
        sbc_pkg::REG_START_Z: sz_r <= cfg_data;
        sbc_pkg::REG_END_X:   ex_r <= cfg_data;
        sbc_pkg::REG_END_Z:   ez_r <= cfg_data;
      endcase
    end
  end

  // slab bounds and start in doubled units
  always_comb begin
    if (axis_r == sbc_pkg::AX_Z) begin
      p1   = sz_r;
      p2   = ez_r;
      cc   = cz_r;
      size = cd_r;
    end else begin
      p1   = sx_r;
      p2   = ex_r;
      cc   = cx_r;
      size = cw_r;
    end
  end

  assign c2     = {{(BW-C-1){cc[C-1]}}, cc, 1'b0};
  assign sz_e   = {{(BW-SW){1'b0}}, size};
  assign lo     = c2 - sz_e;
  assign hi     = c2 + sz_e;
  assign s      = {{(BW-C-1){p1[C-1]}}, p1, 1'b0};
  assign diff   = {p2[C-1], p2} - {p1[C-1], p1};
  assign d      = {diff, 1'b0};
  assign dzero  = (diff == '0);
  assign start_in_slab = (lo <= s) && (s <= hi);
  assign num_lo = {lo[BW-1], lo} - {s[BW-1], s};
  assign num_hi = {hi[BW-1], hi} - {s[BW-1], s};
  assign div_num = (state_r == ST_AXIS) ? num_lo : num_hi;

  // clip of the parameter interval by the two slab bounds
  assign tmin = (t1_r <= t_div) ? t1_r : t_div;
  assign tmax = (t1_r <= t_div) ? t_div : t1_r;
  assign ne   = (tmin > entry_r) ? tmin : entry_r;
  assign nx   = (tmax < exit_r) ? tmax : exit_r;
  assign ok   = (ne <= nx);

  sbc_divider #(
    .NUM_W     (NW),
    .DEN_W     (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d),
    .t     (t_div),
    .stat  (div_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cx_nxt    = cx_r;
    cz_nxt    = cz_r;
    cw_nxt    = cw_r;
    cd_nxt    = cd_r;
    last_nxt  = last_r;
    hit_nxt   = hit_r;
    entry_nxt = entry_r;
    exit_nxt  = exit_r;
    t1_nxt    = t1_r;
    seen_nxt  = seen_r;
    ov_nxt    = ov_r && !out_ready;
    ob_nxt    = ob_r;
    op_nxt    = op_r;
    ol_nxt    = ol_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cx_nxt    = in_cell_x;
          cz_nxt    = in_cell_z;
          cw_nxt    = in_cell_width;
          cd_nxt    = in_cell_depth;
          last_nxt  = in_last_cell;
          axis_nxt  = sbc_pkg::AX_X;
          hit_nxt   = 1'b0;
          entry_nxt = '0;
          exit_nxt  = TW'(1) << FRAC_BITS;
          state_nxt = in_is_endpoint ? ST_DONE : ST_AXIS;
        end
      end
      ST_AXIS: begin
        if (dzero) begin
          // no motion along this axis: only the start position decides
          if (!start_in_slab) begin
            hit_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else if (axis_r == sbc_pkg::AX_Z) begin
            hit_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            axis_nxt  = sbc_pkg::AX_Z;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_LO;
        end
      end
      ST_DIV_LO: begin
        if (div_stat.done) begin
          t1_nxt    = t_div;
          div_start = 1'b1;
          state_nxt = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        if (div_stat.done) begin
          entry_nxt = ne;
          exit_nxt  = nx;
          if (!ok) begin
            hit_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else if (axis_r == sbc_pkg::AX_Z) begin
            hit_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            axis_nxt  = sbc_pkg::AX_Z;
            state_nxt = ST_AXIS;
          end
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ob_nxt    = hit_r;
          op_nxt    = seen_r || hit_r;
          ol_nxt    = last_r;
          seen_nxt  = (seen_r || hit_r) && !last_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      ov_r    <= ov_nxt;
    end
    axis_r  <= axis_nxt;
    cx_r    <= cx_nxt;
    cz_r    <= cz_nxt;
    cw_r    <= cw_nxt;
    cd_r    <= cd_nxt;
    last_r  <= last_nxt;
    hit_r   <= hit_nxt;
    entry_r <= entry_nxt;
    exit_r  <= exit_nxt;
    t1_r    <= t1_nxt;
    ob_r    <= ob_nxt;
    op_r    <= op_nxt;
    ol_r    <= ol_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = ov_r;
  assign out_cell_blocks  = ob_r;
  assign out_path_blocked = op_r;
  assign out_list_done    = ol_r;

  // checks
  `SBC_ASSERT(a_accept_busy, in_valid && in_ready |=> !in_ready, "item accepted but still idle")
  `SBC_ASSERT(a_div_free, div_start |-> !div_stat.busy, "divider started while busy")
  `SBC_ASSERT(a_blk_sticky, out_valid && out_cell_blocks |-> out_path_blocked,
              "blocking cell without path flag")
  `SBC_ASSERT_RST(a_reset, !rst_n |=> !out_valid && in_ready, "reset left block busy")

endmodule

// ===== hw/rtl/sbc_divider.sv =====
`include "segment_blocked_by_cells_unit_macros.svh"

module sbc_divider #(
  parameter int NUM_W     = 27,
  parameter int DEN_W     = 26,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [DEN_W-1:0]  den,
  output logic signed [FRAC_BITS+1:0] t,
  output sbc_pkg::div_stat_t       stat
);

  localparam int TW    = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 2;
  localparam int D4W   = DEN_W + 2;
  localparam int CMPW  = (NUM_W > D4W) ? NUM_W : D4W;
  localparam int CNT_W = $clog2(QW + 1);

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RUN  = 2'd1;
  localparam logic [1:0] DS_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [D4W-1:0]   r_r, r_nxt;
  logic [D4W-1:0]   d4_r, d4_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             neg_r, neg_nxt;
  logic             done_r, done_nxt;
  logic signed [TW-1:0] t_r, t_nxt;

  logic [NUM_W-1:0] num_u, num_mag;
  logic [DEN_W-1:0] den_u, den_mag;
  logic [CMPW-1:0]  num_ext, d4_ext;
  logic [D4W:0]     r2, rsub;
  logic             ge;
  logic [QW:0]      m;
  logic signed [TW-1:0] t_calc;

  // operand magnitudes
  assign num_u   = num;
  assign den_u   = den;
  assign num_mag = num_u[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;
  assign den_mag = den_u[DEN_W-1] ? (~den_u + DEN_W'(1)) : den_u;
  assign num_ext = CMPW'(num_mag);
  assign d4_ext  = CMPW'({den_mag, 2'b00});

  // one restoring step against four times the divisor
  assign r2   = {r_r, 1'b0};
  assign rsub = r2 - {1'b0, d4_r};
  assign ge   = (r2 >= {1'b0, d4_r});

  // sign, rounding toward minus infinity and saturation
  assign m = {1'b0, q_r} + (QW+1)'(r_r != '0);
  always_comb begin
    if (!neg_r) begin
      if (ovf_r || q_r[QW-1]) begin
        t_calc = {1'b0, {(TW-1){1'b1}}};
      end else begin
        t_calc = {1'b0, q_r[QW-2:0]};
      end
    end else begin
      if (ovf_r || (m > ((QW+1)'(1) << (FRAC_BITS + 1)))) begin
        t_calc = {1'b1, {(TW-1){1'b0}}};
      end else begin
        t_calc = (~m[TW-1:0]) + TW'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    d4_nxt    = d4_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    t_nxt     = t_r;
    unique case (state_r)
      DS_IDLE: begin
        if (start) begin
          r_nxt     = num_ext[D4W-1:0];
          d4_nxt    = d4_ext[D4W-1:0];
          ovf_nxt   = (num_ext >= d4_ext);
          neg_nxt   = num_u[NUM_W-1] ^ den_u[DEN_W-1];
          q_nxt     = '0;
          cnt_nxt   = CNT_W'(QW);
          state_nxt = DS_RUN;
        end
      end
      DS_RUN: begin
        r_nxt   = ge ? rsub[D4W-1:0] : r2[D4W-1:0];
        q_nxt   = {q_r[QW-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = DS_FIN;
        end
      end
      DS_FIN: begin
        t_nxt     = t_calc;
        done_nxt  = 1'b1;
        state_nxt = DS_IDLE;
      end
      default: begin
        state_nxt = DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    r_r   <= r_nxt;
    d4_r  <= d4_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
    t_r   <= t_nxt;
  end

  assign t         = t_r;
  assign stat.busy = (state_r != DS_IDLE);
  assign stat.done = done_r;

  // checks
  `SBC_ASSERT(a_start_runs, start && !stat.busy |=> stat.busy, "divider did not start")
  `SBC_ASSERT(a_done_idle, stat.done |-> !stat.busy, "divider done while busy")

endmodule

// ===== tb/segment_blocked_by_cells_unit_tb.sv =====
`timescale 1ns / 100ps

module segment_blocked_by_cells_unit_tb;

  localparam int COORD_W = 24;
  localparam int FRAC_W = 16;
  localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
  localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ROUND_ITEMS = 240;

  typedef struct {
    logic signed [COORD_W-1:0]      x;
    logic signed [COORD_W-1:0]      z;
    logic [sbc_pkg::SIZE_W-1:0]     width;
    logic [sbc_pkg::SIZE_W-1:0]     depth;
    logic                           endpoint;
    logic                           last;
  } cell_t;

  typedef struct {
    logic blocks;
    logic path;
    logic done;
  } verdict_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_index = sbc_pkg::REG_START_X;
  logic [COORD_W-1:0]              cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic signed [COORD_W-1:0]       in_cell_x = '0;
  logic signed [COORD_W-1:0]       in_cell_z = '0;
  logic [sbc_pkg::SIZE_W-1:0]      in_cell_width = '0;
  logic [sbc_pkg::SIZE_W-1:0]      in_cell_depth = '0;
  logic                            in_is_endpoint = 1'b0;
  logic                            in_last_cell = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_cell_blocks;
  logic                            out_path_blocked;
  logic                            out_list_done;

  // segment and sticky flag as the block should hold them
  longint   seg_sx = 0, seg_sz = 0, seg_ex = 0, seg_ez = 0;
  bit       any_blocked = 1'b0;

  cell_t    cell_q[$];
  verdict_t verdict_q[$];
  cell_t    cur_item;
  int       pending_items = 0;
  int       errors = 0;
  int       checked_cnt = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       stall_left = 0;
  bit       hold_done = 1'b0;
  int       idle_cycles = 0;

  segment_blocked_by_cells_unit #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_x       (in_cell_x),
    .in_cell_z       (in_cell_z),
    .in_cell_width   (in_cell_width),
    .in_cell_depth   (in_cell_depth),
    .in_is_endpoint  (in_is_endpoint),
    .in_last_cell    (in_last_cell),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_blocks (out_cell_blocks),
    .out_path_blocked(out_path_blocked),
    .out_list_done   (out_list_done)
  );

  // clock
  always #4 clk = ~clk;

  // floor(num * 2^FRAC / den), sign carried by num, saturated to Q2.FRAC
  function automatic longint slab_param(longint num, longint den);
    longint lim, n, q;
    lim = 64'sd1 <<< (FRAC_W + 1);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    n = num * (64'sd1 <<< FRAC_W);
    if (n >= 0) q = n / den;
    else q = -((-n + den - 1) / den);
    if (q > lim - 1) q = lim - 1;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  // narrow [t_lo, t_hi] by one axis slab, coordinates doubled
  function automatic bit slab_pass(longint p1, longint p2, longint centre, longint size,
                                   inout longint t_lo, inout longint t_hi);
    longint lo, hi, s, d, t1, t2, tmp;
    lo = 2 * centre - size;
    hi = 2 * centre + size;
    s = 2 * p1;
    d = 2 * (p2 - p1);
    // no motion along this axis: start must sit inside the slab
    if (d == 0) return (lo <= s) && (s <= hi);
    t1 = slab_param(lo - s, d);
    t2 = slab_param(hi - s, d);
    if (t1 > t2) begin
      tmp = t1;
      t1 = t2;
      t2 = tmp;
    end
    if (t1 > t_lo) t_lo = t1;
    if (t2 < t_hi) t_hi = t2;
    return t_lo <= t_hi;
  endfunction

  // expected result of one cell, advancing the sticky flag
  function automatic verdict_t cell_verdict(cell_t c);
    longint   t_lo, t_hi;
    bit       hit;
    verdict_t v;
    hit = 1'b0;
    t_lo = 0;
    t_hi = 64'sd1 <<< FRAC_W;
    if (!c.endpoint) begin
      if (slab_pass(seg_sx, seg_ex, longint'(c.x), longint'(c.width), t_lo, t_hi))
        hit = slab_pass(seg_sz, seg_ez, longint'(c.z), longint'(c.depth), t_lo, t_hi);
    end
    if (hit) any_blocked = 1'b1;
    v.blocks = hit;
    v.path = any_blocked;
    v.done = c.last;
    if (c.last) any_blocked = 1'b0;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] to_coord(longint v);
    if (v > 64'sd8388607) return COORD_MAX;
    if (v < -64'sd8388608) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // random cell: mostly placed along the segment, some anywhere
  function automatic cell_t make_cell(bit last_flag);
    cell_t       c;
    logic [31:0] r;
    longint      f, px, pz, spread;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r = $urandom();
      c.x = r[COORD_W-1:0];
      r = $urandom();
      c.z = r[COORD_W-1:0];
      r = $urandom();
      c.width = r[sbc_pkg::SIZE_W-1:0];
      c.depth = r[31:16];
    end else begin
      // point a little past either end now and then
      f = longint'($urandom_range(0, 320)) - 32;
      px = seg_sx + (seg_ex - seg_sx) * f / 256;
      pz = seg_sz + (seg_ez - seg_sz) * f / 256;
      c.width = (pick < 35) ? sbc_pkg::SIZE_W'($urandom_range(0, 65535)) :
                (pick < 40) ? '0 : sbc_pkg::SIZE_W'($urandom_range(0, 2048));
      c.depth = ($urandom_range(0, 3) == 0) ? sbc_pkg::SIZE_W'($urandom_range(0, 65535)) :
                sbc_pkg::SIZE_W'($urandom_range(0, 2048));
      spread = longint'(c.width) + 64;
      c.x = to_coord(px + longint'($urandom_range(0, int'(2 * spread))) - spread);
      spread = longint'(c.depth) + 64;
      c.z = to_coord(pz + longint'($urandom_range(0, int'(2 * spread))) - spread);
    end
    c.endpoint = ($urandom_range(0, 9) == 0);
    c.last = last_flag;
    return c;
  endfunction

  task automatic queue_cell(cell_t c);
    cell_q.insert(cell_q.size(), c);
    pending_items++;
  endtask

  task automatic add_cell(longint x, longint z, int w, int d, bit ep, bit last_flag);
    cell_t c;
    c.x = to_coord(x);
    c.z = to_coord(z);
    c.width = sbc_pkg::SIZE_W'(w);
    c.depth = sbc_pkg::SIZE_W'(d);
    c.endpoint = ep;
    c.last = last_flag;
    queue_cell(c);
  endtask

  // wait until every queued cell has produced its result
  task automatic drain();
    while (pending_items != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, predictor copy updated on acceptance
  task automatic write_reg(logic [sbc_pkg::CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sbc_pkg::REG_START_X: seg_sx = longint'($signed(val));
      sbc_pkg::REG_START_Z: seg_sz = longint'($signed(val));
      sbc_pkg::REG_END_X:   seg_ex = longint'($signed(val));
      sbc_pkg::REG_END_Z:   seg_ez = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_segment(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sz,
                             logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ez);
    drain();
    write_reg(sbc_pkg::REG_START_X, sx);
    write_reg(sbc_pkg::REG_START_Z, sz);
    write_reg(sbc_pkg::REG_END_X, ex);
    write_reg(sbc_pkg::REG_END_Z, ez);
    cfg_valid <= 1'b0;
  endtask

  // driver: predicts each accepted cell, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) verdict_q.insert(verdict_q.size(), cell_verdict(cur_item));
      if (!in_valid || in_ready) begin
        if (cell_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = cell_q.pop_front();
          in_valid <= 1'b1;
          in_cell_x <= cur_item.x;
          in_cell_z <= cur_item.z;
          in_cell_width <= cur_item.width;
          in_cell_depth <= cur_item.depth;
          in_is_endpoint <= cur_item.endpoint;
          in_last_cell <= cur_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with no cell pending");
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_cell_blocks !== want.blocks) begin
            $error("cell_blocks: expected %0d, got %0d", want.blocks, out_cell_blocks);
            errors++;
          end
          if (out_path_blocked !== want.path) begin
            $error("path_blocked: expected %0d, got %0d", want.path, out_path_blocked);
            errors++;
          end
          if (out_list_done !== want.done) begin
            $error("list_done: expected %0d, got %0d", want.done, out_list_done);
            errors++;
          end
          pending_items--;
          checked_cnt++;
        end
      end
      // one long hold-off so the block backs up into its input
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (checked_cnt == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [31:0] ra, rb, rc, rd;
    int          made, len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset segment is a point at the origin: both axes motionless
    add_cell(0, 0, 0, 0, 1'b0, 1'b0);
    add_cell(1, 0, 2, 0, 1'b0, 1'b0);
    add_cell(1, 0, 1, 65535, 1'b0, 1'b1);
    add_cell(0, 0, 0, 0, 1'b1, 1'b1);

    // diagonal: zero-size touch, endpoint cell, extremes, segment ends
    set_segment(to_coord(-1000), to_coord(-500), to_coord(3000), to_coord(2500));
    add_cell(1000, 1000, 0, 0, 1'b0, 1'b0);
    add_cell(1000, 1000, 100, 100, 1'b1, 1'b0);
    add_cell(-8388608, -8388608, 65535, 65535, 1'b0, 1'b0);
    add_cell(8388607, 8388607, 0, 0, 1'b0, 1'b1);
    add_cell(-1000, -500, 0, 0, 1'b0, 1'b1);
    add_cell(3000, 2500, 65535, 65535, 1'b0, 1'b1);
    // x slab misses, z would pass
    add_cell(20000, 1000, 100, 65535, 1'b0, 1'b1);

    // vertical segment: x motionless, slab edge exactly on start
    set_segment(to_coord(100), to_coord(-2000), to_coord(100), to_coord(2000));
    add_cell(100, 0, 0, 10, 1'b0, 1'b0);
    add_cell(150, 0, 100, 10, 1'b0, 1'b0);
    add_cell(151, 0, 100, 10, 1'b0, 1'b1);

    // horizontal segment: z motionless
    set_segment(to_coord(-2000), to_coord(-7), to_coord(2000), to_coord(-7));
    add_cell(0, -7, 10, 0, 1'b0, 1'b0);
    add_cell(0, 0, 10, 13, 1'b0, 1'b1);

    // full-range diagonal
    set_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    add_cell(0, 0, 65535, 65535, 1'b0, 1'b0);
    add_cell(8388607, -8388608, 65535, 65535, 1'b0, 1'b0);
    add_cell(-8388608, -8388608, 0, 0, 1'b0, 1'b1);

    // random lists under a range of segments and idling patterns
    for (int r = 0; r < 8; r++) begin
      ra = $urandom();
      rb = $urandom();
      rc = $urandom();
      rd = $urandom();
      case (r)
        1: set_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        2: set_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        3: set_segment(ra[23:0], rb[23:0], ra[23:0], rd[23:0]);
        4: set_segment(ra[23:0], rb[23:0], rc[23:0], rb[23:0]);
        5: set_segment(ra[23:0], rb[23:0],
                       to_coord(longint'($signed(ra[23:0])) + rc[15:0] - 32768),
                       to_coord(longint'($signed(rb[23:0])) + rd[15:0] - 32768));
        6: set_segment(ra[23:0], rb[23:0], ra[23:0], rb[23:0]);
        default: set_segment(ra[23:0], rb[23:0], rc[23:0], rd[23:0]);
      endcase
      case (r % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      made = 0;
      while (made < ROUND_ITEMS) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) queue_cell(make_cell(k == len - 1));
        made += len;
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d predicted results never arrived", verdict_q.size());
      errors++;
    end
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
